// ===== rtl/core/ols_pkg.sv =====
// Shared types and constants for the ordered list store.
package ols_pkg;

  localparam int OLS_CAPACITY = 16;
  localparam int OLS_DATA_W   = 32;

  // Command codes carried in the cmd field of a request.
  typedef enum logic [2:0] {
    CMD_INS_TAIL = 3'd0,
    CMD_INS_HEAD = 3'd1,
    CMD_RM_HEAD  = 3'd2,
    CMD_RM_TAIL  = 3'd3,
    CMD_RM_AT    = 3'd4,
    CMD_SEARCH   = 3'd5
  } ols_cmd_t;

  typedef struct packed {
    logic [2:0]                   cmd;
    logic signed [OLS_DATA_W-1:0] value;
    logic [4:0]                   position;
  } ols_req_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] found_position;
    logic [4:0] count;
  } ols_rsp_t;

endpackage

// ===== rtl/core/ols_entry_ram.sv =====
// Entry storage: one write port and one read port with registered read data.
module ols_entry_ram #(
  parameter int  DEPTH  = 16,
  parameter int  DATA_W = 32,
  localparam int AW     = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ordered_list_store_unit.sv =====
// Top level of the ordered list store: command sequencer around the entry memory.
// Insert tail, remove tail, insert head on an empty list, remove head or at a position when no
// entry moves, an unknown command and any request refused for a full or empty list or a bad
// position answer in the cycle after acceptance. Else insert head shifts every entry up, a remove
// shifts later entries down, a search compares from the head to a match or the tail, one entry
// moved or compared per cycle. busy falls as the strobe shows, so the next request is taken
// then; the receiver cannot stall. Reset clears the count; entries stay undefined.
module ordered_list_store_unit #(
  parameter int CAPACITY = ols_pkg::OLS_CAPACITY
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  ols_pkg::ols_req_t in_req,
  output logic             out_strobe,
  output ols_pkg::ols_rsp_t out_rsp
);

  import ols_pkg::*;

  // Index width covers the entries; count width must also hold CAPACITY itself.
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  // Widths used to line up the 5-bit position field and results with the count.
  localparam int PW = (CW > 5) ? CW : 5;
  localparam int FW = (IW + 1 > 5) ? IW + 1 : 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_TAIL,
    ST_HEAD_WR,
    ST_DOWN,
    ST_DRAIN,
    ST_SCAN,
    ST_SCAN_END
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [OLS_DATA_W-1:0] val_r, val_nxt;
  // A shift moves an entry in two steps: read in one cycle, write the next.
  logic                  wpend_r, wpend_nxt;
  logic [IW-1:0]         waddr_r, waddr_nxt;
  // A search compares the entry read in the previous cycle.
  logic                  cpend_r, cpend_nxt;
  logic [IW-1:0]         cidx_r, cidx_nxt;
  logic                  ostb_r, ostb_nxt;
  ols_rsp_t              orsp_r, orsp_nxt;

  logic                  mem_we;
  logic [IW-1:0]         mem_waddr;
  logic [OLS_DATA_W-1:0] mem_wdata;
  logic                  mem_re;
  logic [IW-1:0]         mem_raddr;
  logic [OLS_DATA_W-1:0] mem_rdata;

  logic                  full;
  logic                  empty;
  logic                  hit;
  logic                  last_down;
  logic [PW-1:0]         pos_ext;
  logic [PW-1:0]         cnt_ext;
  logic [FW-1:0]         found_ext;

  ols_entry_ram #(
    .DEPTH  (CAPACITY),
    .DATA_W (OLS_DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  function automatic logic [4:0] cnt5(input logic [CW-1:0] c);
    logic [PW-1:0] e;
    e = PW'(c);
    return e[4:0];
  endfunction

  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign hit       = cpend_r && (mem_rdata == val_r);
  assign last_down = (CW'(idx_r) == count_r - CW'(1));
  assign pos_ext   = PW'(in_req.position);
  assign cnt_ext   = PW'(count_r);
  assign found_ext = FW'(cidx_r) + FW'(1);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    wpend_nxt = 1'b0;
    waddr_nxt = waddr_r;
    cpend_nxt = 1'b0;
    cidx_nxt  = cidx_r;
    ostb_nxt  = 1'b0;
    orsp_nxt  = orsp_r;
    mem_we    = 1'b0;
    mem_waddr = waddr_r;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          val_nxt = in_req.value;
          // Default answer is a failure that leaves the store as it is.
          ostb_nxt                = 1'b1;
          orsp_nxt.ok             = 1'b0;
          orsp_nxt.found_position = '0;
          orsp_nxt.count          = cnt5(count_r);
          case (in_req.cmd)
            CMD_INS_TAIL: begin
              if (!full) begin
                mem_we         = 1'b1;
                mem_waddr      = count_r[IW-1:0];
                mem_wdata      = in_req.value;
                count_nxt      = count_r + CW'(1);
                orsp_nxt.ok    = 1'b1;
                orsp_nxt.count = cnt5(count_nxt);
              end
            end
            CMD_INS_HEAD: begin
              if (empty) begin
                mem_we         = 1'b1;
                mem_waddr      = '0;
                mem_wdata      = in_req.value;
                count_nxt      = CW'(1);
                orsp_nxt.ok    = 1'b1;
                orsp_nxt.count = cnt5(count_nxt);
              end else if (!full) begin
                // Move every entry up by one, starting from the tail.
                ostb_nxt  = 1'b0;
                idx_nxt   = IW'(count_r - CW'(1));
                state_nxt = ST_UP;
              end
            end
            CMD_RM_HEAD: begin
              if (count_r == CW'(1)) begin
                count_nxt      = '0;
                orsp_nxt.ok    = 1'b1;
                orsp_nxt.count = cnt5(count_nxt);
              end else if (!empty) begin
                ostb_nxt  = 1'b0;
                idx_nxt   = IW'(1);
                state_nxt = ST_DOWN;
              end
            end
            CMD_RM_TAIL: begin
              if (!empty) begin
                count_nxt      = count_r - CW'(1);
                orsp_nxt.ok    = 1'b1;
                orsp_nxt.count = cnt5(count_nxt);
              end
            end
            CMD_RM_AT: begin
              if (pos_ext == cnt_ext && !empty) begin
                // Removing the last entry needs no move.
                count_nxt      = count_r - CW'(1);
                orsp_nxt.ok    = 1'b1;
                orsp_nxt.count = cnt5(count_nxt);
              end else if (pos_ext != '0 && pos_ext < cnt_ext) begin
                // Entries after the removed one each move down by one.
                ostb_nxt  = 1'b0;
                idx_nxt   = IW'(pos_ext);
                state_nxt = ST_DOWN;
              end
            end
            CMD_SEARCH: begin
              if (!empty) begin
                ostb_nxt  = 1'b0;
                idx_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_UP: begin
        mem_re    = 1'b1;
        mem_we    = wpend_r;
        wpend_nxt = 1'b1;
        waddr_nxt = idx_r + IW'(1);
        if (idx_r == '0) begin
          state_nxt = ST_UP_TAIL;
        end else begin
          idx_nxt = idx_r - IW'(1);
        end
      end

      ST_UP_TAIL: begin
        mem_we    = 1'b1;
        state_nxt = ST_HEAD_WR;
      end

      ST_HEAD_WR: begin
        mem_we                  = 1'b1;
        mem_waddr               = '0;
        mem_wdata               = val_r;
        count_nxt               = count_r + CW'(1);
        ostb_nxt                = 1'b1;
        orsp_nxt.ok             = 1'b1;
        orsp_nxt.found_position = '0;
        orsp_nxt.count          = cnt5(count_nxt);
        state_nxt               = ST_IDLE;
      end

      ST_DOWN: begin
        mem_re    = 1'b1;
        mem_we    = wpend_r;
        wpend_nxt = 1'b1;
        waddr_nxt = idx_r - IW'(1);
        if (last_down) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      ST_DRAIN: begin
        mem_we                  = 1'b1;
        count_nxt               = count_r - CW'(1);
        ostb_nxt                = 1'b1;
        orsp_nxt.ok             = 1'b1;
        orsp_nxt.found_position = '0;
        orsp_nxt.count          = cnt5(count_nxt);
        state_nxt               = ST_IDLE;
      end

      ST_SCAN: begin
        if (hit) begin
          ostb_nxt                = 1'b1;
          orsp_nxt.ok             = 1'b1;
          orsp_nxt.found_position = found_ext[4:0];
          orsp_nxt.count          = cnt5(count_r);
          state_nxt               = ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          cpend_nxt = 1'b1;
          cidx_nxt  = idx_r;
          if (last_down) begin
            state_nxt = ST_SCAN_END;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end

      ST_SCAN_END: begin
        ostb_nxt                = 1'b1;
        orsp_nxt.ok             = hit;
        orsp_nxt.found_position = hit ? found_ext[4:0] : 5'd0;
        orsp_nxt.count          = cnt5(count_r);
        state_nxt               = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      wpend_r <= 1'b0;
      cpend_r <= 1'b0;
      ostb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      wpend_r <= wpend_nxt;
      cpend_r <= cpend_nxt;
      ostb_r  <= ostb_nxt;
      idx_r   <= idx_nxt;
      val_r   <= val_nxt;
      waddr_r <= waddr_nxt;
      cidx_r  <= cidx_nxt;
      orsp_r  <= orsp_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = ostb_r;
  assign out_rsp    = orsp_r;

endmodule

// ===== dv/ordered_list_store_unit_tb.sv =====
// Self-checking testbench for the ordered list store: directed corner cases plus random command streams.
module ordered_list_store_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ols_pkg::*;

  // The two command codes that the package leaves unassigned; the block must
  // treat them as no-ops that report failure.
  localparam logic [2:0] CMD_RSVD_LO = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  localparam logic signed [OLS_DATA_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [OLS_DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  // After the last response, this many quiet cycles outlast the longest request
  // (insert head on a nearly full list), so they catch any late or spurious strobe.
  localparam int DRAIN_CYCLES = 40;

  logic     clk;
  logic     rst_n  = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  ols_req_t in_req = '0;
  logic     out_strobe;
  ols_rsp_t out_rsp;

  // Shadow copy of the list contents, head at index 0.
  logic signed [OLS_DATA_W-1:0] shadow_list[$];
  // Responses predicted for accepted requests, oldest first.
  ols_rsp_t pending_rsp_q[$];
  int       mismatch_count = 0;
  // When set, the sender never inserts a gap between requests.
  bit       no_idle = 1'b0;

  ordered_list_store_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Applies one request to the shadow list and returns the response the block
  // should give for it. Requests are handled strictly in order, so updating the
  // shadow at acceptance time keeps it in step with the block.
  function automatic ols_rsp_t apply_to_shadow(ols_req_t req);
    ols_rsp_t rsp;
    rsp = '0;
    case (req.cmd)
      CMD_INS_TAIL: begin
        if (shadow_list.size() < OLS_CAPACITY) begin
          shadow_list.push_back(req.value);
          rsp.ok = 1'b1;
        end
      end
      CMD_INS_HEAD: begin
        if (shadow_list.size() < OLS_CAPACITY) begin
          shadow_list.push_front(req.value);
          rsp.ok = 1'b1;
        end
      end
      CMD_RM_HEAD: begin
        if (shadow_list.size() > 0) begin
          void'(shadow_list.pop_front());
          rsp.ok = 1'b1;
        end
      end
      CMD_RM_TAIL: begin
        if (shadow_list.size() > 0) begin
          void'(shadow_list.pop_back());
          rsp.ok = 1'b1;
        end
      end
      CMD_RM_AT: begin
        // Positions are 1-based; zero and anything past the tail are rejected.
        if (req.position >= 1 && req.position <= shadow_list.size()) begin
          shadow_list.delete(req.position - 1);
          rsp.ok = 1'b1;
        end
      end
      CMD_SEARCH: begin
        // The first match wins, so duplicates report the position nearest the head.
        for (int i = 0; i < shadow_list.size(); i++) begin
          if (shadow_list[i] == req.value) begin
            rsp.ok             = 1'b1;
            rsp.found_position = 5'(i + 1);
            break;
          end
        end
      end
      default: ;
    endcase
    rsp.count = 5'(shadow_list.size());
    return rsp;
  endfunction

  function automatic ols_req_t make_req(logic [2:0] cmd, logic signed [OLS_DATA_W-1:0] value,
                                        logic [4:0] position);
    ols_req_t req;
    req.cmd      = cmd;
    req.value    = value;
    req.position = position;
    return req;
  endfunction

  // Values come from a small pool half the time, so inserts create duplicates
  // and searches hit, and otherwise from the full 32-bit range.
  function automatic logic signed [OLS_DATA_W-1:0] pick_value();
    case ($urandom_range(5))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return OLS_DATA_W'($signed($urandom_range(7)) - 3);
      default: return $urandom;
    endcase
  endfunction

  // Search keys hit a stored value most of the time.
  function automatic logic signed [OLS_DATA_W-1:0] pick_search_key();
    if (shadow_list.size() > 0 && $urandom_range(99) < 65)
      return shadow_list[$urandom_range(shadow_list.size() - 1)];
    return pick_value();
  endfunction

  // Positions for remove-at are mostly in range, the rest anywhere the field allows.
  function automatic logic [4:0] pick_position();
    if (shadow_list.size() > 0 && $urandom_range(99) < 75)
      return 5'($urandom_range(1, shadow_list.size()));
    return 5'($urandom_range(31));
  endfunction

  // Sends one request. Called at a rising edge; returns at the edge where the
  // request was taken, with start still high so that back-to-back requests
  // never lower and raise it within one time step. A random gap drops start
  // and puts noise on the request bus, which the block must ignore.
  task automatic send_request(ols_req_t req);
    int gap;
    if (!no_idle && $urandom_range(99) < 23) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
      start  <= 1'b0;
      in_req <= ols_req_t'(40'({$urandom, $urandom}));
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy !== 1'b0);
    pending_rsp_q.push_back(apply_to_shadow(req));
  endtask

  task automatic send_random_mix(int n);
    int       roll;
    ols_req_t req;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 20)      req = make_req(CMD_INS_TAIL, pick_value(), 5'($urandom));
      else if (roll < 38) req = make_req(CMD_INS_HEAD, pick_value(), 5'($urandom));
      else if (roll < 50) req = make_req(CMD_RM_HEAD, $urandom, 5'($urandom));
      else if (roll < 61) req = make_req(CMD_RM_TAIL, $urandom, 5'($urandom));
      else if (roll < 76) req = make_req(CMD_RM_AT, $urandom, pick_position());
      else if (roll < 96) req = make_req(CMD_SEARCH, pick_search_key(), 5'($urandom));
      else if (roll < 98) req = make_req(CMD_RSVD_LO, pick_value(), 5'($urandom));
      else                req = make_req(CMD_RSVD_HI, pick_value(), 5'($urandom));
      send_request(req);
    end
  endtask

  // Corner cases: all commands but insert head on an empty list, unknown
  // commands, value extremes at both ends, duplicate search, bad remove-at positions.
  task automatic test_directed();
    send_request(make_req(CMD_RM_HEAD, '0, '0));
    send_request(make_req(CMD_RM_TAIL, '0, '0));
    send_request(make_req(CMD_RM_AT, '0, 5'd1));
    send_request(make_req(CMD_SEARCH, '0, '0));
    send_request(make_req(CMD_RSVD_LO, VAL_MAX, 5'd31));
    send_request(make_req(CMD_RSVD_HI, VAL_MIN, 5'd1));
    send_request(make_req(CMD_INS_TAIL, VAL_MIN, '0));
    send_request(make_req(CMD_INS_HEAD, VAL_MAX, '0));
    send_request(make_req(CMD_INS_TAIL, '0, 5'd31));
    send_request(make_req(CMD_INS_HEAD, -1, '0));
    send_request(make_req(CMD_INS_TAIL, -1, '0));
    send_request(make_req(CMD_SEARCH, -1, '0));
    send_request(make_req(CMD_SEARCH, VAL_MIN, '0));
    send_request(make_req(CMD_SEARCH, 32'sd1, '0));
    send_request(make_req(CMD_RSVD_LO, '0, 5'd2));
    send_request(make_req(CMD_RM_AT, '0, 5'd0));
    send_request(make_req(CMD_RM_AT, '0, 5'd6));
    send_request(make_req(CMD_RM_AT, '0, 5'd31));
    send_request(make_req(CMD_RM_AT, '0, 5'd5));
    send_request(make_req(CMD_RM_AT, '0, 5'd2));
    send_request(make_req(CMD_SEARCH, -1, '0));
    send_request(make_req(CMD_RM_HEAD, '0, '0));
    send_request(make_req(CMD_SEARCH, -1, '0));
    send_request(make_req(CMD_RM_AT, '0, 5'd1));
    send_request(make_req(CMD_RM_TAIL, '0, '0));
  endtask

  // Repeatedly fills the list to capacity and empties it again, so full and
  // empty rejections and the longest shifts and scans are exercised often.
  task automatic test_fill_and_drain(int rounds);
    int roll;
    for (int r = 0; r < rounds; r++) begin
      while (shadow_list.size() < OLS_CAPACITY) begin
        roll = $urandom_range(99);
        if (roll < 40)      send_request(make_req(CMD_INS_TAIL, pick_value(), 5'($urandom)));
        else if (roll < 80) send_request(make_req(CMD_INS_HEAD, pick_value(), 5'($urandom)));
        else                send_request(make_req(CMD_SEARCH, pick_search_key(), 5'($urandom)));
      end
      send_request(make_req(CMD_INS_HEAD, pick_value(), 5'($urandom)));
      send_request(make_req(CMD_INS_TAIL, pick_value(), 5'($urandom)));
      send_request(make_req(CMD_SEARCH, pick_search_key(), 5'($urandom)));
      send_request(make_req(CMD_RM_AT, $urandom, 5'(OLS_CAPACITY)));
      send_request(make_req(CMD_INS_HEAD, pick_value(), 5'($urandom)));
      while (shadow_list.size() > 0) begin
        roll = $urandom_range(99);
        if (roll < 25)      send_request(make_req(CMD_RM_HEAD, $urandom, 5'($urandom)));
        else if (roll < 45) send_request(make_req(CMD_RM_TAIL, $urandom, 5'($urandom)));
        else if (roll < 80) send_request(make_req(CMD_RM_AT, $urandom, pick_position()));
        else                send_request(make_req(CMD_SEARCH, pick_search_key(), 5'($urandom)));
      end
      send_request(make_req(CMD_RM_HEAD, $urandom, 5'($urandom)));
      send_request(make_req(CMD_RM_TAIL, $urandom, 5'($urandom)));
    end
  endtask

  // A mixed command stream with random gaps between requests.
  task automatic test_random_mix();
    send_random_mix(300);
  endtask

  // Requests offered on every cycle, so each is taken the cycle busy falls.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    send_random_mix(130);
    no_idle = 1'b0;
  endtask

  // Each strobe is compared against the oldest prediction. Sampling at the
  // rising edge sees the values the block drove during the ending cycle.
  always @(posedge clk) begin
    ols_rsp_t exp_rsp;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_rsp_q.size() == 0) begin
        $error("response with no request pending: ok=%0b found_position=%0d count=%0d",
               out_rsp.ok, out_rsp.found_position, out_rsp.count);
        mismatch_count++;
      end else begin
        exp_rsp = pending_rsp_q.pop_front();
        if (out_rsp.ok !== exp_rsp.ok) begin
          $error("ok: expected %0b, got %0b", exp_rsp.ok, out_rsp.ok);
          mismatch_count++;
        end
        if (out_rsp.found_position !== exp_rsp.found_position) begin
          $error("found_position: expected %0d, got %0d",
                 exp_rsp.found_position, out_rsp.found_position);
          mismatch_count++;
        end
        if (out_rsp.count !== exp_rsp.count) begin
          $error("count: expected %0d, got %0d", exp_rsp.count, out_rsp.count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_mix();
    test_fill_and_drain(8);
    test_back_to_back();
    start <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Well above the slowest legal run: about 850 requests at the longest
  // operation plus the longest sender gap each.
  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== ordered_list_store_unit.f =====
rtl/core/ols_pkg.sv
rtl/core/ols_entry_ram.sv
rtl/core/ordered_list_store_unit.sv
dv/ordered_list_store_unit_tb.sv
